// ----- hw/rtl/msd_pkg.sv -----
package msd_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_BITS  = 8;
   localparam int unsigned CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAYOUT = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VOLUME = 8'd1;

   // Channel layout codes; codes ten and up mix as stereo.
   localparam int unsigned LAYOUT_BITS = 4;
   typedef enum logic [LAYOUT_BITS-1:0] {
      LAY_MONO     = 4'd0,
      LAY_STEREO   = 4'd1,
      LAY_QUAD     = 4'd2,
      LAY_2P1      = 4'd3,
      LAY_4P1      = 4'd4,
      LAY_SURROUND = 4'd5,
      LAY_5P1      = 4'd6,
      LAY_5P1_SUR  = 4'd7,
      LAY_7P1      = 4'd8,
      LAY_7P1_SUR  = 4'd9
   } lay_type;

   localparam logic [LAYOUT_BITS-1:0] LAYOUT_RESET = LAY_STEREO;

   // Volume is unsigned Q1.15.
   localparam int unsigned VOL_BITS      = 16;
   localparam int unsigned VOL_FRAC_BITS = 15;
   localparam logic [VOL_BITS-1:0] VOLUME_RESET = 16'd32768;

   // Mix gains as Q32 values; rounded to the coefficient precision in the top level.
   localparam logic [63:0] Q32_MINUS3DB = 64'd3037000500;
   localparam logic [63:0] Q32_LFE      = 64'd9603838835;

endpackage

// ----- hw/rtl/msd_if.sv -----
// Frame input channel: eight signed channel samples per word.
interface msd_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_ch0;
   logic signed [SAMPLE_BITS-1:0] sample_ch1;
   logic signed [SAMPLE_BITS-1:0] sample_ch2;
   logic signed [SAMPLE_BITS-1:0] sample_ch3;
   logic signed [SAMPLE_BITS-1:0] sample_ch4;
   logic signed [SAMPLE_BITS-1:0] sample_ch5;
   logic signed [SAMPLE_BITS-1:0] sample_ch6;
   logic signed [SAMPLE_BITS-1:0] sample_ch7;

   modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   sample_ch4, sample_ch5, sample_ch6, sample_ch7, input ready);
   modport sink   (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   sample_ch4, sample_ch5, sample_ch6, sample_ch7, output ready);
endinterface

// Stereo result channel.
interface msd_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;
   logic                          clipped;

   modport source (output valid, out_left, out_right, clipped, input ready);
   modport sink   (input valid, out_left, out_right, clipped, output ready);
endinterface

// Configuration write channel.
interface msd_csr_if
   import msd_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/multichannel_stereo_downmix_unit.sv -----
// Surround to stereo downmix.
//
// The req_if channel carries one audio frame per word: up to eight signed
// channel samples whose meaning depends on the channel layout register. The
// rsp_if channel returns one word per frame with the left and right mix and a
// flag that is set when either side hit the sample rails. The csr_if channel
// writes the layout (index 0) and the Q1.15 volume (index 1); writes to other
// indexes are dropped. Configuration should only change while no frame is in
// flight.
//
// The datapath is a six-stage pipeline: operand select, gain multiply, sum,
// round, volume multiply, and round plus saturate into the output register.
// One frame is accepted every cycle unless a stall backs the input up. A
// stall on rsp_if holds the stalled stages; the empty stages ahead of it
// keep filling, so the input only backs up once all six stages hold words.
// Reset empties the pipeline and sets the layout to stereo and the volume
// to unity.
module multichannel_stereo_downmix_unit
   import msd_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic      clock,
   input  logic      reset,
   msd_req_if.sink   req_if,
   msd_rsp_if.source rsp_if,
   msd_csr_if.sink   csr_if
);

   localparam int SB  = SAMPLE_BITS;
   localparam int FB  = COEF_FRAC_BITS;
   // Gains stay below four, so two integer bits hold the largest one.
   localparam int CW  = FB + 2;
   // The accumulated mix is below eight times full scale.
   localparam int AW  = SB + FB + 5;
   localparam int MW  = AW - FB;
   localparam int PW  = MW + VOL_BITS + 1;
   localparam int SW  = PW - VOL_FRAC_BITS;
   localparam int NSTG = 6;

   localparam logic [CW-1:0] G_ONE  = CW'(64'd1 << FB);
   localparam logic [CW-1:0] G_HALF = CW'(64'd1 << (FB - 1));
   localparam logic [CW-1:0] G_M3   = CW'(((Q32_MINUS3DB >> (31 - FB)) + 64'd1) >> 1);
   localparam logic [CW-1:0] G_LFE  = CW'(((Q32_LFE >> (31 - FB)) + 64'd1) >> 1);

   localparam logic signed [AW-1:0] ACC_HALF = AW'(64'd1 << (FB - 1));
   localparam logic signed [PW-1:0] VOL_HALF = PW'(64'd1 << (VOL_FRAC_BITS - 1));
   localparam logic signed [SB-1:0] SAT_MAX  = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAT_MIN  = {1'b1, {(SB-1){1'b0}}};

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [LAYOUT_BITS-1:0] layout_ff;
   logic [VOL_BITS-1:0]    volume_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_RESET;
         volume_ff <= VOLUME_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         if (csr_if.index == CSR_LAYOUT) begin
            layout_ff <= csr_if.wdata[LAYOUT_BITS-1:0];
         end
         if (csr_if.index == CSR_VOLUME) begin
            volume_ff <= csr_if.wdata[VOL_BITS-1:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage loads whenever it is empty or the
   // stage after it loads, so bubbles collapse during a stall.
   // ------------------------------------------------------------------
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] stg_rdy;
   logic [NSTG-1:0] vld_in;

   always_comb begin
      stg_rdy[NSTG-1] = !vld_ff[NSTG-1] || rsp_if.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stg_rdy[k] = !vld_ff[k] || stg_rdy[k+1];
      end
      vld_in[0] = req_if.valid;
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (stg_rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_if.ready = stg_rdy[0];

   // ------------------------------------------------------------------
   // Stage 1: pick operands and gains for the layout. Every layout fits
   //   left  = base_l + center + lfe + extra_l - rear
   //   right = base_r + center + lfe + extra_r + rear
   // with unused terms zeroed. Two rear channels, where the layout has them, are summed here.
   // ------------------------------------------------------------------
   logic signed [SB-1:0] base_l_in, base_r_in, cen_in, lfe_in, xl_in, xr_in;
   logic signed [SB:0]   rear_in;
   logic [CW-1:0]        cen_g_in, rear_g_in, x_g_in;

   logic signed [SB-1:0] base_l_ff, base_r_ff, cen_ff, lfe_ff, xl_ff, xr_ff;
   logic signed [SB:0]   rear_ff;
   logic [CW-1:0]        cen_g_ff, rear_g_ff, x_g_ff;

   always_comb begin
      base_l_in = req_if.sample_ch0;
      base_r_in = req_if.sample_ch1;
      cen_in    = '0;
      lfe_in    = '0;
      xl_in     = '0;
      xr_in     = '0;
      rear_in   = '0;
      cen_g_in  = G_M3;
      rear_g_in = G_M3;
      x_g_in    = G_HALF;
      unique case (layout_ff)
         LAY_MONO: begin
            base_r_in = req_if.sample_ch0;
         end
         LAY_QUAD: begin
            rear_in = (SB+1)'(req_if.sample_ch2) + (SB+1)'(req_if.sample_ch3);
         end
         LAY_2P1: begin
            lfe_in = req_if.sample_ch2;
         end
         LAY_4P1: begin
            lfe_in  = req_if.sample_ch2;
            rear_in = (SB+1)'(req_if.sample_ch3) + (SB+1)'(req_if.sample_ch4);
         end
         LAY_SURROUND: begin
            cen_in    = req_if.sample_ch2;
            rear_in   = (SB+1)'(req_if.sample_ch3);
            rear_g_in = G_HALF;
         end
         LAY_5P1: begin
            cen_in  = req_if.sample_ch2;
            lfe_in  = req_if.sample_ch3;
            rear_in = (SB+1)'(req_if.sample_ch4) + (SB+1)'(req_if.sample_ch5);
         end
         LAY_5P1_SUR: begin
            // Side channels add on their own side at -3 dB.
            cen_in = req_if.sample_ch2;
            lfe_in = req_if.sample_ch3;
            xl_in  = req_if.sample_ch4;
            xr_in  = req_if.sample_ch5;
            x_g_in = G_M3;
         end
         LAY_7P1: begin
            cen_in   = req_if.sample_ch2;
            cen_g_in = G_HALF;
            lfe_in   = req_if.sample_ch3;
            rear_in  = (SB+1)'(req_if.sample_ch4) + (SB+1)'(req_if.sample_ch5);
            xl_in    = req_if.sample_ch6;
            xr_in    = req_if.sample_ch7;
         end
         LAY_7P1_SUR: begin
            cen_in    = req_if.sample_ch2;
            lfe_in    = req_if.sample_ch3;
            rear_in   = (SB+1)'(req_if.sample_ch4) + (SB+1)'(req_if.sample_ch5);
            rear_g_in = G_HALF;
            xl_in     = req_if.sample_ch6;
            xr_in     = req_if.sample_ch7;
         end
         default: begin
            // Stereo and the unused codes pass the front pair through.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[0]) begin
         base_l_ff <= base_l_in;
         base_r_ff <= base_r_in;
         cen_ff    <= cen_in;
         lfe_ff    <= lfe_in;
         xl_ff     <= xl_in;
         xr_ff     <= xr_in;
         rear_ff   <= rear_in;
         cen_g_ff  <= cen_g_in;
         rear_g_ff <= rear_g_in;
         x_g_ff    <= x_g_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: gain multiplies. The unity gain on the front pair is a shift.
   // ------------------------------------------------------------------
   logic signed [AW-1:0] pbl_in, pbr_in, pc_in, plfe_in, prear_in, pxl_in, pxr_in;
   logic signed [AW-1:0] pbl_ff, pbr_ff, pc_ff, plfe_ff, prear_ff, pxl_ff, pxr_ff;

   always_comb begin
      pbl_in   = {{(AW-SB-FB){base_l_ff[SB-1]}}, base_l_ff, {FB{1'b0}}};
      pbr_in   = {{(AW-SB-FB){base_r_ff[SB-1]}}, base_r_ff, {FB{1'b0}}};
      pc_in    = AW'(cen_ff * $signed({1'b0, cen_g_ff}));
      plfe_in  = AW'(lfe_ff * $signed({1'b0, G_LFE}));
      prear_in = AW'(rear_ff * $signed({1'b0, rear_g_ff}));
      pxl_in   = AW'(xl_ff * $signed({1'b0, x_g_ff}));
      pxr_in   = AW'(xr_ff * $signed({1'b0, x_g_ff}));
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         pbl_ff   <= pbl_in;
         pbr_ff   <= pbr_in;
         pc_ff    <= pc_in;
         plfe_ff  <= plfe_in;
         prear_ff <= prear_in;
         pxl_ff   <= pxl_in;
         pxr_ff   <= pxr_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: exact sums of the weighted terms. Rear is subtracted on the
   // left and added on the right.
   // ------------------------------------------------------------------
   logic signed [AW-1:0] acc_l_in, acc_r_in, acc_l_ff, acc_r_ff;

   assign acc_l_in = pbl_ff + pc_ff + plfe_ff + pxl_ff - prear_ff;
   assign acc_r_in = pbr_ff + pc_ff + plfe_ff + pxr_ff + prear_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[2]) begin
         acc_l_ff <= acc_l_in;
         acc_r_ff <= acc_r_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: round to whole sample units, half up, no saturation yet.
   // ------------------------------------------------------------------
   logic signed [AW-1:0] rnd_l, rnd_r;
   logic signed [MW-1:0] mix_l_in, mix_r_in, mix_l_ff, mix_r_ff;

   always_comb begin
      rnd_l    = acc_l_ff + ACC_HALF;
      rnd_r    = acc_r_ff + ACC_HALF;
      mix_l_in = rnd_l[AW-1:FB];
      mix_r_in = rnd_r[AW-1:FB];
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[3]) begin
         mix_l_ff <= mix_l_in;
         mix_r_ff <= mix_r_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: volume multiply.
   // ------------------------------------------------------------------
   logic signed [PW-1:0] vol_l_in, vol_r_in, vol_l_ff, vol_r_ff;

   assign vol_l_in = PW'(mix_l_ff * $signed({1'b0, volume_ff}));
   assign vol_r_in = PW'(mix_r_ff * $signed({1'b0, volume_ff}));

   always_ff @(posedge clock) begin
      if (stg_rdy[4]) begin
         vol_l_ff <= vol_l_in;
         vol_r_ff <= vol_r_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: drop the volume fraction with rounding, then saturate. A
   // value fits the sample range when all bits above its sign bit agree.
   // ------------------------------------------------------------------
   logic signed [PW-1:0] vr_l, vr_r;
   logic signed [SW-1:0] sc_l, sc_r;
   logic [SW-SB:0]       top_l, top_r;
   logic                 ovf_l, ovf_r;
   logic signed [SB-1:0] out_l_in, out_r_in, out_l_ff, out_r_ff;
   logic                 clip_in, clip_ff;

   always_comb begin
      vr_l  = vol_l_ff + VOL_HALF;
      vr_r  = vol_r_ff + VOL_HALF;
      sc_l  = vr_l[PW-1:VOL_FRAC_BITS];
      sc_r  = vr_r[PW-1:VOL_FRAC_BITS];
      top_l = sc_l[SW-1:SB-1];
      top_r = sc_r[SW-1:SB-1];
      ovf_l = !((&top_l) || (~|top_l));
      ovf_r = !((&top_r) || (~|top_r));
      if (ovf_l) begin
         out_l_in = sc_l[SW-1] ? SAT_MIN : SAT_MAX;
      end else begin
         out_l_in = sc_l[SB-1:0];
      end
      if (ovf_r) begin
         out_r_in = sc_r[SW-1] ? SAT_MIN : SAT_MAX;
      end else begin
         out_r_in = sc_r[SB-1:0];
      end
      clip_in = ovf_l || ovf_r;
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[5]) begin
         out_l_ff <= out_l_in;
         out_r_ff <= out_r_in;
         clip_ff  <= clip_in;
      end
   end

   assign rsp_if.valid     = vld_ff[NSTG-1];
   assign rsp_if.out_left  = out_l_ff;
   assign rsp_if.out_right = out_r_ff;
   assign rsp_if.clipped   = clip_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // A clipped word carries at least one output on a rail.
   a_clip_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.clipped) |->
         (out_l_ff == SAT_MAX || out_l_ff == SAT_MIN ||
          out_r_ff == SAT_MAX || out_r_ff == SAT_MIN))
      else $error("clipped flag set without a saturated output");

   // With the output register empty, every stage can move and input is open.
   a_open_when_drained: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[NSTG-1] |-> req_if.ready)
      else $error("input stalled while the output register is empty");

   // A full mid stage that cannot advance keeps its word.
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && !stg_rdy[3]) |=> vld_ff[2])
      else $error("pipeline word lost during a stall");

endmodule

// ----- tb/sv/multichannel_stereo_downmix_unit_tb.sv -----
`timescale 1ns / 100ps

module multichannel_stereo_downmix_unit_tb
   import msd_pkg::*;
   ;

   localparam int SB = 24;
   localparam int CF = 14;

   typedef logic signed [SB-1:0] sample_type;
   typedef logic [7:0][SB-1:0]   frame_type;

   // One stereo result word as the block should give it.
   typedef struct packed {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
      logic                 clip;
   } mix_type;

   // Mix gains at the coefficient precision, rounded to nearest from the
   // Q32 values in the package.
   localparam longint GAIN_ONE  = longint'(1) <<< CF;
   localparam longint GAIN_HALF = longint'(1) <<< (CF - 1);
   localparam longint GAIN_M3   = longint'(((Q32_MINUS3DB >> (31 - CF)) + 64'd1) >> 1);
   localparam longint GAIN_LFE  = longint'(((Q32_LFE >> (31 - CF)) + 64'd1) >> 1);

   localparam longint     RAIL_HI = (longint'(1) <<< (SB - 1)) - 1;
   localparam longint     RAIL_LO = -RAIL_HI - 1;
   localparam sample_type S_MAX   = {1'b0, {(SB-1){1'b1}}};
   localparam sample_type S_MIN   = {1'b1, {(SB-1){1'b0}}};

   // Layout codes past the last named one all mix as stereo.
   localparam logic [LAYOUT_BITS-1:0] LAY_UNUSED_FIRST = 4'(LAY_7P1_SUR) + 4'd1;
   localparam logic [LAYOUT_BITS-1:0] LAY_UNUSED_LAST  = '1;

   // Register indexes the block does not decode; writes there are dropped.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = CSR_VOLUME + 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = '1;

   // Pipeline depth given at the head of the block, plus some margin.
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msd_req_if #(.SAMPLE_BITS(SB)) req_if ();
   msd_rsp_if #(.SAMPLE_BITS(SB)) rsp_if ();
   msd_csr_if                     csr_if ();

   multichannel_stereo_downmix_unit #(
      .SAMPLE_BITS   (SB),
      .COEF_FRAC_BITS(CF)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always #6 clock = ~clock;

   // Our own copy of the two registers. It only changes while the block is
   // idle, so the driver can read it when a frame is accepted.
   logic [LAYOUT_BITS-1:0] layout_cfg = LAYOUT_RESET;
   logic [VOL_BITS-1:0]    volume_cfg = VOLUME_RESET;

   frame_type pending_frames [$];
   mix_type   expected_mixes [$];
   int        mismatches = 0;
   bit        gaps_on = 1'b1;

   // Rounds a Q(CF) sum to sample units, applies the Q1.15 volume with the
   // same add-half-then-floor rounding, and clamps to the sample rails.
   function automatic sample_type scale_to_rails(longint acc, logic [VOL_BITS-1:0] vol,
                                                 output bit hit);
      longint mixed;
      longint scaled;
      mixed  = (acc + (longint'(1) <<< (CF - 1))) >>> CF;
      scaled = (mixed * longint'(vol) + (longint'(1) <<< (VOL_FRAC_BITS - 1)))
               >>> VOL_FRAC_BITS;
      hit = 1'b0;
      if (scaled > RAIL_HI) begin
         hit    = 1'b1;
         scaled = RAIL_HI;
      end else if (scaled < RAIL_LO) begin
         hit    = 1'b1;
         scaled = RAIL_LO;
      end
      return scaled[SB-1:0];
   endfunction

   // Folds one frame down to stereo for the given layout and volume.
   function automatic mix_type downmix(frame_type f, logic [LAYOUT_BITS-1:0] lay,
                                       logic [VOL_BITS-1:0] vol);
      longint  s [8];
      longint  l, r, c, lfe, rear;
      bit      hit_l, hit_r;
      mix_type res;
      for (int i = 0; i < 8; i++)
         s[i] = longint'($signed(f[i]));
      case (lay)
         LAY_MONO: begin
            l = s[0] * GAIN_ONE;
            r = l;
         end
         LAY_QUAD: begin
            rear = (s[2] + s[3]) * GAIN_M3;
            l = s[0] * GAIN_ONE - rear;
            r = s[1] * GAIN_ONE + rear;
         end
         LAY_2P1: begin
            lfe = s[2] * GAIN_LFE;
            l = s[0] * GAIN_ONE + lfe;
            r = s[1] * GAIN_ONE + lfe;
         end
         LAY_4P1: begin
            lfe  = s[2] * GAIN_LFE;
            rear = (s[3] + s[4]) * GAIN_M3;
            l = s[0] * GAIN_ONE + lfe - rear;
            r = s[1] * GAIN_ONE + lfe + rear;
         end
         LAY_SURROUND: begin
            c    = s[2] * GAIN_M3;
            rear = s[3] * GAIN_HALF;
            l = s[0] * GAIN_ONE + c - rear;
            r = s[1] * GAIN_ONE + c + rear;
         end
         LAY_5P1: begin
            c    = s[2] * GAIN_M3;
            lfe  = s[3] * GAIN_LFE;
            rear = (s[4] + s[5]) * GAIN_M3;
            l = s[0] * GAIN_ONE + c + lfe - rear;
            r = s[1] * GAIN_ONE + c + lfe + rear;
         end
         LAY_5P1_SUR: begin
            c   = s[2] * GAIN_M3;
            lfe = s[3] * GAIN_LFE;
            l = s[0] * GAIN_ONE + c + s[4] * GAIN_M3 + lfe;
            r = s[1] * GAIN_ONE + c + s[5] * GAIN_M3 + lfe;
         end
         LAY_7P1: begin
            c    = s[2] * GAIN_HALF;
            lfe  = s[3] * GAIN_LFE;
            rear = (s[4] + s[5]) * GAIN_M3;
            l = s[0] * GAIN_ONE + s[6] * GAIN_HALF + c + lfe - rear;
            r = s[1] * GAIN_ONE + s[7] * GAIN_HALF + c + lfe + rear;
         end
         LAY_7P1_SUR: begin
            c    = s[2] * GAIN_M3;
            lfe  = s[3] * GAIN_LFE;
            rear = (s[4] + s[5]) * GAIN_HALF;
            l = s[0] * GAIN_ONE + s[6] * GAIN_HALF + c + lfe - rear;
            r = s[1] * GAIN_ONE + s[7] * GAIN_HALF + c + lfe + rear;
         end
         default: begin
            // Stereo, and every unused code, is a straight copy.
            l = s[0] * GAIN_ONE;
            r = s[1] * GAIN_ONE;
         end
      endcase
      res.left  = scale_to_rails(l, vol, hit_l);
      res.right = scale_to_rails(r, vol, hit_r);
      res.clip  = hit_l | hit_r;
      return res;
   endfunction

   // Random samples lean on the rails and on values near zero, so that the
   // rounding and the saturation both see plenty of traffic.
   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return sample_type'(int'($urandom_range(0, 512)) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      for (int i = 0; i < 8; i++)
         f[i] = random_sample();
      return f;
   endfunction

   // ------------------------------------------------------------------
   // Frame driver. It offers words from pending_frames in bursts of random
   // length with random gaps in between, and holds a word steady while the
   // block stalls. The expected mix is worked out at the edge where a word
   // is accepted, from the word on the bus and the current registers.
   // ------------------------------------------------------------------
   int        burst_left = 0;
   int        gap_left = 0;
   frame_type next_frame;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_mixes.push_back(downmix({req_if.sample_ch7, req_if.sample_ch6,
                                              req_if.sample_ch5, req_if.sample_ch4,
                                              req_if.sample_ch3, req_if.sample_ch2,
                                              req_if.sample_ch1, req_if.sample_ch0},
                                             layout_cfg, volume_cfg));
         // A new word may only go out once the current one is gone.
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
               next_frame = pending_frames.pop_front();
               req_if.sample_ch0 <= next_frame[0];
               req_if.sample_ch1 <= next_frame[1];
               req_if.sample_ch2 <= next_frame[2];
               req_if.sample_ch3 <= next_frame[3];
               req_if.sample_ch4 <= next_frame[4];
               req_if.sample_ch5 <= next_frame[5];
               req_if.sample_ch6 <= next_frame[6];
               req_if.sample_ch7 <= next_frame[7];
               req_if.valid <= 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else if (gaps_on) begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = $urandom_range(1, 7);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor and receiver. Each accepted result word is checked
   // against the oldest expected mix. The ready pattern switches between a
   // few modes every so often: always ready, mostly ready, rarely ready and
   // a fixed one-in-four stall. A few times during the run, while plenty of
   // frames are still waiting to go out, it also holds ready low for a long
   // stretch, so the six pipeline stages fill up and the input backs up
   // behind them.
   // ------------------------------------------------------------------
   mix_type     want;
   int          results_seen = 0;
   int          next_hold_at = 300;
   int          hold_left = 0;
   int          rsp_mode = 0;
   int          mode_left = 0;
   logic [1:0]  beat = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_mixes.size() == 0) begin
               $display("%0t: unexpected result word: left %0d right %0d clipped %0b",
                        $time, rsp_if.out_left, rsp_if.out_right, rsp_if.clipped);
               mismatches++;
            end else begin
               want = expected_mixes.pop_front();
               if (rsp_if.out_left !== want.left) begin
                  $display("%0t: out_left expected %0d actual %0d",
                           $time, want.left, rsp_if.out_left);
                  mismatches++;
               end
               if (rsp_if.out_right !== want.right) begin
                  $display("%0t: out_right expected %0d actual %0d",
                           $time, want.right, rsp_if.out_right);
                  mismatches++;
               end
               if (rsp_if.clipped !== want.clip) begin
                  $display("%0t: clipped expected %0b actual %0b",
                           $time, want.clip, rsp_if.clipped);
                  mismatches++;
               end
            end
         end

         beat <= beat + 2'd1;
         if (mode_left == 0) begin
            rsp_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 256);
         end else begin
            mode_left--;
         end
         if (hold_left == 0 && results_seen >= next_hold_at &&
             pending_frames.size() >= 16) begin
            hold_left = LONG_HOLD_CYCLES;
            next_hold_at += 700;
         end

         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (rsp_mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_if.ready <= ($urandom_range(0, 9) < 3);
               default: rsp_if.ready <= (beat != 2'd0);
            endcase
         end
      end
   end

   // Waits until every queued frame has been accepted and every expected
   // word has come back, then lets the pipeline go quiet. The sender is
   // paused for the whole of it, which is also when registers may change.
   // The queues are looked at on the falling edge, once the driver and the
   // monitor have both settled.
   task automatic wait_idle();
      while (pending_frames.size() != 0 || req_if.valid || expected_mixes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write on the configuration channel. Our copy of the
   // register follows at the edge where the write is taken.
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CSR_LAYOUT)
         layout_cfg = data[LAYOUT_BITS-1:0];
      else if (idx == CSR_VOLUME)
         volume_cfg = data;
   endtask

   task automatic set_mix(logic [LAYOUT_BITS-1:0] lay, logic [VOL_BITS-1:0] vol);
      wait_idle();
      write_reg(CSR_LAYOUT, {12'($urandom), lay});
      write_reg(CSR_VOLUME, vol);
   endtask

   // ------------------------------------------------------------------
   // Stimulus. A short directed part first, then random phases, each with
   // its own layout, volume and idling style.
   // ------------------------------------------------------------------
   frame_type              f;
   logic [LAYOUT_BITS-1:0] lay;
   logic [VOL_BITS-1:0]    vol;
   int                     drain_wait;

   initial begin
      req_if.valid = 1'b0;
      req_if.sample_ch0 = '0;
      req_if.sample_ch1 = '0;
      req_if.sample_ch2 = '0;
      req_if.sample_ch3 = '0;
      req_if.sample_ch4 = '0;
      req_if.sample_ch5 = '0;
      req_if.sample_ch6 = '0;
      req_if.sample_ch7 = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.wdata = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: stereo copy at unity. Silence, both rails, and the
      // two front channels at opposite rails.
      pending_frames.push_back('0);
      pending_frames.push_back({8{S_MAX}});
      pending_frames.push_back({8{S_MIN}});
      f = random_frame();
      f[0] = S_MAX;
      f[1] = S_MIN;
      pending_frames.push_back(f);
      f = random_frame();
      f[0] = S_MIN;
      f[1] = S_MAX;
      pending_frames.push_back(f);

      // 7.1 surround at full volume: everything on the top rail clips, and
      // a lone right side channel must land on the right output only.
      set_mix(LAY_7P1_SUR, '1);
      pending_frames.push_back({8{S_MAX}});
      f = '0;
      f[7] = S_MAX;
      pending_frames.push_back(f);
      f = '0;
      f[6] = S_MIN;
      f[7] = S_MIN;
      pending_frames.push_back(f);

      // Zero volume silences even a full-scale frame, with no clip flag.
      set_mix(LAY_7P1_SUR, '0);
      pending_frames.push_back({8{S_MAX}});

      // An unused layout code mixes as stereo; writes to undecoded indexes
      // must not disturb either register.
      set_mix(LAY_UNUSED_FIRST + 4'd2, VOLUME_RESET);
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, 16'($urandom));
      f = '0;
      f[0] = S_MAX;
      f[1] = S_MIN;
      pending_frames.push_back(f);

      // The remaining layouts, each with a full-scale frame of mixed signs.
      f = {S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN};
      set_mix(LAY_MONO, VOLUME_RESET);
      pending_frames.push_back(f);
      set_mix(LAY_QUAD, VOLUME_RESET);
      pending_frames.push_back(f);
      set_mix(LAY_2P1, VOLUME_RESET);
      pending_frames.push_back(f);
      set_mix(LAY_4P1, VOLUME_RESET);
      pending_frames.push_back(~f);
      set_mix(LAY_SURROUND, VOLUME_RESET);
      pending_frames.push_back(f);
      set_mix(LAY_5P1, VOLUME_RESET);
      pending_frames.push_back(~f);
      set_mix(LAY_5P1_SUR, VOLUME_RESET);
      pending_frames.push_back(f);
      set_mix(LAY_7P1, VOLUME_RESET);
      pending_frames.push_back(~f);

      // Random phases. Most use a named layout; a few use the unused codes.
      for (int phase = 0; phase < 24; phase++) begin
         if ($urandom_range(0, 9) < 8)
            lay = 4'($urandom_range(0, int'(LAY_7P1_SUR)));
         else
            lay = 4'($urandom_range(int'(LAY_UNUSED_FIRST), int'(LAY_UNUSED_LAST)));
         case ($urandom_range(0, 5))
            0:       vol = '0;
            1:       vol = '1;
            2:       vol = VOLUME_RESET;
            5:       vol = 16'($urandom_range(1, 1024));
            default: vol = 16'($urandom);
         endcase
         set_mix(lay, vol);
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_BITS'($urandom_range(int'(CSR_SPARE_LO), 15)) | CSR_SPARE_LO,
                      16'($urandom));
         // Some phases run back to back with no gaps from the sender.
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(50, 90))
            pending_frames.push_back(random_frame());
      end

      // Let everything drain, then give the pipeline time to show any word
      // it should not have.
      while (pending_frames.size() != 0 || req_if.valid)
         @(negedge clock);
      drain_wait = 0;
      while (expected_mixes.size() != 0 && drain_wait < 20000) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_mixes.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, expected_mixes.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("multichannel_stereo_downmix_unit_tb: PASS");
      end else begin
         $display("multichannel_stereo_downmix_unit_tb: FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #(10_000_000);
      $display("multichannel_stereo_downmix_unit_tb: FAIL");
      $finish;
   end

endmodule
